FILE: sv/rau_pkg.sv
// Package for the rational arithmetic unit: sequencer states, mode and
// status codes, and the request/response structs of the shared divider.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_NEG = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_INDET    = 2'd2;

  localparam logic [63:0] NUM_MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DEN_MAX     = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD,
    ST_MOD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rau_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } rau_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } rau_div_rsp_t;

endpackage

FILE: sv/rau_if.sv
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on nothing; the payloads follow the operand and result fields.
`timescale 1ns / 1ps
interface rau_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [31:0] a_numer;
  logic signed [31:0] a_denom;
  logic signed [31:0] b_numer;
  logic signed [31:0] b_denom;

  modport source (output valid, mode, a_numer, a_denom, b_numer, b_denom, input ready);
  modport sink (input valid, mode, a_numer, a_denom, b_numer, b_denom, output ready);
endinterface

interface rau_out_if;
  logic              valid;
  logic              ready;
  logic signed [63:0] res_numer;
  logic [61:0]       res_denom;
  logic [1:0]        status;

  modport source (output valid, res_numer, res_denom, status, input ready);
  modport sink (input valid, res_numer, res_denom, status, output ready);
endinterface

FILE: sv/rau_divider.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for the request and response structs.
`timescale 1ns / 1ps
module rau_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rau_pkg::rau_div_req_t req,
  output rau_pkg::rau_div_rsp_t rsp
);
  import rau_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [64:0] shifted;
  logic        ge;

  assign shifted = {rem_r, quo_r[63]};
  assign ge      = (shifted >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so 64 bits hold it.
      rem_nxt = ge ? 64'(shifted - {1'b0, dsr_r}) : shifted[63:0];
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: sv/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: operand capture, shared multiplier,
// Euclid sequencer and result register. Depends on rau_pkg, rau_if, rau_divider.
`timescale 1ns / 1ps
// Adds, subtracts, multiplies or divides two fractions, or negates the first,
// and returns the result reduced by the gcd with a non-negative denominator.
// One item is taken at a time. It passes through the 32x32 multiplier and
// a combining step for the products. Each remainder step of Euclid's algorithm
// is then one issue from ST_GCD and a run of the shared bit-serial 64-bit
// divider, which also does the two final divisions. ST_OUT waits while an
// earlier result is still stalled; once the new result is valid, the unit is
// idle and ready for the next transfer. A zero numerator or denominator needs
// no Euclid step, equal parts need one, and 0/0 skips the divisions.
// Worst-case operands need close to a hundred steps.
// A zero denominator returns +1/0 or -1/0 with status 1, and 0/0 returns
// 0/0 with status 2. A finished result waits in the output register while
// the next item is accepted.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input logic  clk,
  input logic  rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  rau_state_t state_r, state_nxt;

  logic [2:0]         mode_r;
  logic signed [31:0] an_r, ad_r, bn_r, bd_r;
  logic signed [31:0] an_in, ad_in, bn_in, bd_in;
  logic [1:0]         step_r, step_nxt;
  logic signed [63:0] p_r, r_r, q_r;
  logic               nneg_r;
  logic [63:0]        nmag_r, dmag_r, gp_r, gq_r, nq_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_numer_r, res_numer_r;
  logic [61:0]        out_denom_r, res_denom_r;
  logic [1:0]         out_status_r, res_status_r;

  rau_div_req_t div_req;
  rau_div_rsp_t div_rsp;

  // Combine stage signals
  logic        ps, rs, nneg_c, dneg_c;
  logic [63:0] pm, rm, qm, nmag_c;
  // Final stage signals
  logic [63:0] nsat, dsat;

  rau_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign an_in = 32'($signed(in_ch.a_numer[OPERAND_WIDTH-1:0]));
  assign ad_in = 32'($signed(in_ch.a_denom[OPERAND_WIDTH-1:0]));
  assign bn_in = 32'($signed(in_ch.b_numer[OPERAND_WIDTH-1:0]));
  assign bd_in = 32'($signed(in_ch.b_denom[OPERAND_WIDTH-1:0]));

  // Negation is run as an * -1 over ad * 1 so every mode uses the same path.
  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    unique case (step_r)
      2'd0: begin
        mul_a = an_r;
        if (mode_r == MODE_MUL)      mul_b = bn_r;
        else if (mode_r == MODE_NEG) mul_b = -32'sd1;
        else                         mul_b = bd_r;
      end
      2'd1: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_r;
        if (mode_r == MODE_DIV)      mul_b = bn_r;
        else if (mode_r == MODE_NEG) mul_b = 32'sd1;
        else                         mul_b = bd_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    ps     = p_r[63];
    rs     = r_r[63] ^ (mode_r == MODE_SUB);
    pm     = ps ? 64'(-p_r) : p_r;
    rm     = r_r[63] ? 64'(-r_r) : r_r;
    qm     = q_r[63] ? 64'(-q_r) : q_r;
    dneg_c = q_r[63];
    if (mode_r == MODE_MUL || mode_r == MODE_DIV || mode_r == MODE_NEG) begin
      nneg_c = ps;
      nmag_c = pm;
    end else if (ps == rs) begin
      nneg_c = ps;
      nmag_c = pm + rm;
    end else if (pm >= rm) begin
      nneg_c = ps;
      nmag_c = pm - rm;
    end else begin
      nneg_c = rs;
      nmag_c = rm - pm;
    end
  end

  assign nsat = (nq_r > NUM_MAG_MAX) ? NUM_MAG_MAX : nq_r;
  assign dsat = (div_rsp.quotient > DEN_MAX) ? DEN_MAX : div_rsp.quotient;

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    div_req.start    = 1'b0;
    div_req.dividend = nmag_r;
    div_req.divisor  = gp_r;
    out_valid_nxt    = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_ch.valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) state_nxt = ST_COMB;
      end
      ST_COMB: state_nxt = ST_GCD;
      ST_GCD: begin
        if (gp_r == '0 || gq_r == '0) begin
          if ((gp_r | gq_r) == '0) begin
            state_nxt = ST_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = nmag_r;
            div_req.divisor  = gp_r | gq_r;
            state_nxt        = ST_DIVN;
          end
        end else begin
          div_req.start = 1'b1;
          if (gp_r > gq_r) begin
            div_req.dividend = gp_r;
            div_req.divisor  = gq_r;
          end else begin
            div_req.dividend = gq_r;
            div_req.divisor  = gp_r;
          end
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: if (div_rsp.done) state_nxt = ST_GCD;
      ST_DIVN: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = dmag_r;
          div_req.divisor  = gp_r;
          state_nxt        = ST_DIVD;
        end
      end
      ST_DIVD: if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end

    if (state_r == ST_IDLE && in_ch.valid) begin
      mode_r <= in_ch.mode;
      an_r   <= an_in;
      ad_r   <= ad_in;
      bn_r   <= bn_in;
      bd_r   <= bd_in;
    end

    if (state_r == ST_MUL) begin
      unique case (step_r)
        2'd0:    p_r <= prod;
        2'd1:    r_r <= prod;
        default: q_r <= prod;
      endcase
    end

    if (state_r == ST_COMB) begin
      nneg_r <= nneg_c ^ dneg_c;
      nmag_r <= nmag_c;
      dmag_r <= qm;
      gp_r   <= qm;
      gq_r   <= nmag_c;
    end

    if (state_r == ST_GCD) begin
      if ((gp_r | gq_r) == '0) begin
        res_numer_r  <= '0;
        res_denom_r  <= '0;
        res_status_r <= STATUS_INDET;
      end else if (gp_r == '0 || gq_r == '0) begin
        gp_r <= gp_r | gq_r;
      end
    end

    // Same comparison as at issue: the pair is unchanged while the step runs.
    if (state_r == ST_MOD && div_rsp.done) begin
      if (gp_r > gq_r) gp_r <= div_rsp.remainder;
      else             gq_r <= div_rsp.remainder;
    end

    if (state_r == ST_DIVN && div_rsp.done) nq_r <= div_rsp.quotient;

    if (state_r == ST_DIVD && div_rsp.done) begin
      res_numer_r  <= (nneg_r && nsat != '0) ? $signed(64'(-nsat)) : $signed(nsat);
      res_denom_r  <= dsat[61:0];
      res_status_r <= (div_rsp.quotient == '0) ? STATUS_ZERO_DEN : STATUS_OK;
    end

    if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      out_numer_r  <= res_numer_r;
      out_denom_r  <= res_denom_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.res_numer = out_numer_r;
  assign out_ch.res_denom = out_denom_r;
  assign out_ch.status    = out_status_r;

endmodule

FILE: tb/rau_checker.sv
// Checker for the rational arithmetic unit: watches both channels, predicts each
// reduced fraction and compares it with what the block returns. Depends on rau_pkg, rau_if.
`timescale 1ns / 1ps
module rau_checker (
  input logic clk,
  input logic rst_n,
  rau_in_if.sink in_ch,
  rau_out_if.sink out_ch,
  output int err_count,
  output int pending,
  output int seen_results
);
  import rau_pkg::*;

  typedef struct {
    logic signed [63:0] numer;
    logic [61:0]        denom;
    logic [1:0]         status;
  } fraction_t;

  fraction_t expected_q[$];

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] p, input logic [63:0] q);
    while (p != 0 && q != 0) begin
      if (p > q) p = p % q;
      else q = q % p;
    end
    return p + q;
  endfunction

  function automatic fraction_t reduce_fraction(input logic [2:0] mode,
      input logic signed [31:0] an32, input logic signed [31:0] ad32,
      input logic signed [31:0] bn32, input logic signed [31:0] bd32);
    logic signed [63:0] an, ad, bn, bd, p, q, r;
    logic nneg, dneg, ps, rs;
    logic [63:0] nmag, dmag, pm, rm, g;
    fraction_t f;
    an = an32; ad = ad32; bn = bn32; bd = bd32;
    if (mode == MODE_MUL) begin
      p = an * bn; q = ad * bd;
      nneg = p[63]; nmag = mag64(p); dneg = q[63]; dmag = mag64(q);
    end else if (mode == MODE_DIV) begin
      p = an * bd; q = ad * bn;
      nneg = p[63]; nmag = mag64(p); dneg = q[63]; dmag = mag64(q);
    end else if (mode == MODE_NEG) begin
      nneg = an > 0; nmag = mag64(an); dneg = ad[63]; dmag = mag64(ad);
    end else begin
      p = an * bd; r = ad * bn; q = ad * bd;
      ps = p[63]; rs = r[63]; pm = mag64(p); rm = mag64(r);
      if (mode == MODE_SUB) rs = !rs;
      if (ps == rs) begin
        nneg = ps; nmag = pm + rm;
      end else if (pm >= rm) begin
        nneg = ps; nmag = pm - rm;
      end else begin
        nneg = rs; nmag = rm - pm;
      end
      dneg = q[63]; dmag = mag64(q);
    end
    if (dneg) nneg = !nneg;
    g = gcd64(dmag, nmag);
    if (g == 0) begin
      f.numer = 0; f.denom = 0; f.status = STATUS_INDET;
      return f;
    end
    nmag = nmag / g;
    dmag = dmag / g;
    f.status = (dmag == 0) ? STATUS_ZERO_DEN : STATUS_OK;
    if (nmag > NUM_MAG_MAX) nmag = NUM_MAG_MAX;
    if (dmag > DEN_MAX) dmag = DEN_MAX;
    f.numer = (nneg && nmag != 0) ? -nmag : nmag;
    f.denom = dmag[61:0];
    return f;
  endfunction

  initial pending = 0;

  always @(posedge clk) begin
    fraction_t e;
    if (!rst_n) begin
      err_count <= 0;
      seen_results <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(reduce_fraction(in_ch.mode, in_ch.a_numer, in_ch.a_denom,
                                             in_ch.b_numer, in_ch.b_denom));
      if (out_ch.valid && out_ch.ready) begin
        seen_results <= seen_results + 1;
        if (expected_q.size() == 0) begin
          if (err_count < 10) $display("ERROR: result transfer with nothing expected");
          err_count <= err_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.numer !== out_ch.res_numer || e.denom !== out_ch.res_denom ||
              e.status !== out_ch.status) begin
            if (err_count < 10)
              $display("ERROR: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                       e.numer, e.denom, e.status, out_ch.res_numer,
                       out_ch.res_denom, out_ch.status);
            err_count <= err_count + 1;
          end
        end
      end
    end
    // Sized right after this edge's updates, so it is settled by the falling edge.
    pending = expected_q.size();
  end
endmodule

FILE: tb/rational_arithmetic_unit_test.sv
// Testbench top for the rational arithmetic unit: drives operand transfers with
// bursts and gaps, stalls the result side, and reports. Depends on rau_pkg, rau_if, rau_checker.
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int N_RANDOM = 1130;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int err_count, pending, seen_results;
  longint cycles = 0;
  int sent = 0;

  rau_in_if in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit #(.OPERAND_WIDTH(32)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rau_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
    .err_count(err_count), .pending(pending), .seen_results(seen_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("FAIL rational_arithmetic_unit");
      $finish;
    end
  end

  // The receiver alternates stall-free stretches with random stall patterns.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 2000) % 3 == 0) out_ch.ready <= 1'b1;
    else if ((stall_phase / 2000) % 3 == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 9) < 2);
  end

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return 32'sh7FFF_FFFF;
      4: return -32'sh7FFF_FFFF;
      5: return 32'($urandom_range(0, 40)) - 32'sd20;
      6: return 32'($urandom_range(1, 12)) * 32'($urandom_range(1, 720));
      default: return $urandom;
    endcase
  endfunction

  // Holds one item on the channel until its transfer completes.
  task automatic send_item(input logic [2:0] mode, input logic signed [31:0] an,
      input logic signed [31:0] ad, input logic signed [31:0] bn,
      input logic signed [31:0] bd);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.a_numer <= an;
    in_ch.a_denom <= ad;
    in_ch.b_numer <= bn;
    in_ch.b_denom <= bd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 300)) @(negedge clk);
  endtask

  initial begin
    int burst;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.a_numer = 0;
    in_ch.a_denom = 0;
    in_ch.b_numer = 0;
    in_ch.b_denom = 0;
    out_ch.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every mode, field extremes, zero denominators, 0/0, unused modes.
    send_item(MODE_ADD, 1, 2, 1, 3);
    send_item(MODE_SUB, 1, 2, 1, 2);
    send_item(MODE_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_item(MODE_DIV, -32'sh7FFF_FFFF, 3, 32'sh7FFF_FFFF, -7);
    send_item(MODE_NEG, 6, -4, 0, 0);
    send_item(MODE_NEG, 0, 0, 5, 5);
    send_item(MODE_ADD, 5, 0, 1, 1);
    send_item(MODE_MUL, -3, 1, 2, 0);
    send_item(MODE_ADD, 0, 0, 0, 0);
    send_item(MODE_DIV, 0, 5, 0, 7);
    send_item(MODE_MUL, 0, 9, 4, -3);
    send_item(3'd5, 1, 4, 1, 4);
    send_item(3'd6, -1, 3, 2, 3);
    send_item(3'd7, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
    send_item(MODE_MUL, 32'sh8000_0000, 32'sh8000_0001, 32'sh8000_0000, 1);
    send_item(MODE_SUB, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFE);
    send_item(MODE_DIV, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    send_item(MODE_NEG, -32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_ADD, 832040, 1346269, 514229, 832040);
    in_ch.valid <= 1'b0;

    // Let the block drain completely before the random part.
    while (pending != 0) @(negedge clk);

    while (sent < N_RANDOM + 19) begin
      burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (burst)
        send_item(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
      if ($urandom_range(0, 1) == 0) send_gap();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    $display("Sent %0d operand pairs over all five modes plus unused codes;", sent);
    $display("checked %0d reduced results including zero and 0/0 denominators.",
             seen_results);
    if (err_count == 0 && pending == 0)
      $display("PASS rational_arithmetic_unit");
    else
      $display("FAIL rational_arithmetic_unit");
    $finish;
  end
endmodule
